FILE: hw/rtl/lr_pkg.sv
// Shared types, constants and helpers for the line rasterizer.
package lr_pkg;

    localparam int X_W         = 9;
    localparam int Y_W         = 8;
    localparam int POS_W       = 9;
    localparam int ERR_W       = 11;
    localparam int COLOUR_W    = 16;
    localparam int ADDR_W      = 32;
    localparam int ROW_SHIFT   = 10;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 72;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic                  steep;
        logic [POS_W-1:0]      major_pos;
        logic [POS_W-1:0]      major_stop;
        logic [POS_W-1:0]      major_delta;
        logic [POS_W-1:0]      minor_pos;
        logic [POS_W-1:0]      minor_delta;
        logic                  minor_down;
        logic [COLOUR_W-1:0]   colour;
    } t_line_cmd;

    typedef struct packed {
        logic drawing;
        logic pix_issue;
        logic pix_last;
    } t_back_status;

    function automatic logic [ADDR_W-1:0] pixel_addr(
        input logic [ADDR_W-1:0] base,
        input logic [X_W-1:0]    x,
        input logic [Y_W-1:0]    y
    );
        logic [ADDR_W-1:0] row_off;
        logic [ADDR_W-1:0] col_off;
        row_off = ADDR_W'(y) << ROW_SHIFT;
        col_off = ADDR_W'(x) << 1;
        return base + row_off + col_off;
    endfunction

endpackage

FILE: hw/rtl/line_rasterizer_top.sv
// Line rasterizer: Bresenham front end, command queue and drawing engine.
// An accepted step request is held in the command queue, then its pixel is registered in the output register.
// Sustained throughput is one request per cycle while the master side takes pixels; the queue holds four requests.
// Line setup is combinational in the front end.
// Reset is synchronous and active low; it empties the queue, ends any line,
// drops the output request and clears the frame base to zero.
module line_rasterizer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lr_pkg::ADDR_W-1:0]      i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // start_x[8:0], start_y[16:9], end_x[25:17], end_y[33:26], line_colour[49:34], zero pad
    input  logic [lr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // mode[0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixel_x[8:0], pixel_y[16:9], pixel_colour[32:17], pixel_address[64:33], zero pad
    output logic [lr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                           m_axis_tlast
);

    logic [lr_pkg::ADDR_W-1:0] r_frame_base;
    logic                      q_full;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_valid;
    lr_pkg::t_line_cmd         front_cmd;
    lr_pkg::t_line_cmd         q_cmd;
    lr_pkg::t_back_status      back_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= '0;
        end else if (i_cfg_valid) begin
            r_frame_base <= i_cfg_data;
        end
    end

    lr_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .i_tdata       (s_axis_tdata),
        .i_tuser       (s_axis_tuser),
        .i_q_full      (q_full),
        .o_ready       (s_axis_tready),
        .o_push        (q_push),
        .o_cmd         (front_cmd)
    );

    lr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    lr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_base  (r_frame_base),
        .i_q_valid     (q_valid),
        .i_cmd         (q_cmd),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_tdata       (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_status      (back_status)
    );

    a_last_ends_line : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.pix_issue && back_status.pix_last |=> !back_status.drawing)
        else $error("Line still drawing after its last pixel.");

    a_mid_keeps_line : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.pix_issue && !back_status.pix_last |=> back_status.drawing)
        else $error("Line ended before its last pixel.");

    a_issue_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.pix_issue |=> m_axis_tvalid)
        else $error("Issued pixel did not reach the output.");

endmodule

FILE: hw/rtl/lr_front.sv
// Front end: accepts requests and decodes line loads into queue commands.
module lr_front (
    input  logic                           s_axis_tvalid,
    input  logic [lr_pkg::S_TDATA_W-1:0]   i_tdata,
    input  logic                           i_tuser,
    input  logic                           i_q_full,
    output logic                           o_ready,
    output logic                           o_push,
    output lr_pkg::t_line_cmd              o_cmd
);

    logic [lr_pkg::POS_W-1:0] ax, ay, bx, by;
    logic [lr_pkg::POS_W-1:0] dx, dy;
    logic [lr_pkg::POS_W-1:0] p0, q0, p1, q1;
    logic                     steep;
    logic                     swap;
    logic [lr_pkg::POS_W-1:0] maj_lo, maj_hi, min_lo, min_hi;

    assign ax = i_tdata[8:0];
    assign ay = {1'b0, i_tdata[16:9]};
    assign bx = i_tdata[25:17];
    assign by = {1'b0, i_tdata[33:26]};

    assign o_ready = !i_q_full;
    assign o_push  = s_axis_tvalid && !i_q_full;

    always_comb begin
        dx     = (ax > bx) ? (ax - bx) : (bx - ax);
        dy     = (ay > by) ? (ay - by) : (by - ay);
        steep  = dy > dx;
        p0     = steep ? ay : ax;
        q0     = steep ? ax : ay;
        p1     = steep ? by : bx;
        q1     = steep ? bx : by;
        swap   = p0 > p1;
        maj_lo = swap ? p1 : p0;
        maj_hi = swap ? p0 : p1;
        min_lo = swap ? q1 : q0;
        min_hi = swap ? q0 : q1;

        o_cmd.kind        = i_tuser ? lr_pkg::KIND_STEP : lr_pkg::KIND_LOAD;
        o_cmd.steep       = steep;
        o_cmd.major_pos   = maj_lo;
        o_cmd.major_stop  = maj_hi;
        o_cmd.major_delta = maj_hi - maj_lo;
        o_cmd.minor_pos   = min_lo;
        o_cmd.minor_delta = (min_lo > min_hi) ? (min_lo - min_hi) : (min_hi - min_lo);
        o_cmd.minor_down  = min_lo > min_hi;
        o_cmd.colour      = i_tdata[49:34];
    end

endmodule

FILE: hw/rtl/lr_queue.sv
// Short command queue between the front end and the drawing engine.
module lr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lr_pkg::t_line_cmd  i_cmd,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output lr_pkg::t_line_cmd  o_cmd
);

    lr_pkg::t_line_cmd r_entry [lr_pkg::QUEUE_DEPTH];
    logic [lr_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [lr_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [lr_pkg::QUEUE_CW-1:0] r_count, n_count;
    logic                        do_push, do_pop;

    assign o_full  = r_count == lr_pkg::QUEUE_CW'(lr_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/lr_back.sv
// Drawing engine: runs the Bresenham stepping and holds the pixel output register.
module lr_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [lr_pkg::ADDR_W-1:0]      i_frame_base,
    input  logic                           i_q_valid,
    input  lr_pkg::t_line_cmd              i_cmd,
    output logic                           o_q_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [lr_pkg::M_TDATA_W-1:0]   o_tdata,
    output logic                           m_axis_tlast,
    output lr_pkg::t_back_status           o_status
);

    logic                                r_drawing, n_drawing;
    logic                                r_steep;
    logic [lr_pkg::POS_W-1:0]            r_major_pos, n_major_pos;
    logic [lr_pkg::POS_W-1:0]            r_minor_pos, n_minor_pos;
    logic [lr_pkg::POS_W-1:0]            r_major_stop;
    logic [lr_pkg::POS_W-1:0]            r_major_delta;
    logic [lr_pkg::POS_W-1:0]            r_minor_delta;
    logic signed [lr_pkg::ERR_W-1:0]     r_err, n_err;
    logic                                r_minor_down;
    logic [lr_pkg::COLOUR_W-1:0]         r_colour;

    logic                                r_out_valid;
    logic [lr_pkg::X_W-1:0]              r_out_x;
    logic [lr_pkg::Y_W-1:0]              r_out_y;
    logic [lr_pkg::COLOUR_W-1:0]         r_out_colour;
    logic [lr_pkg::ADDR_W-1:0]           r_out_addr;
    logic                                r_out_last;

    logic                                out_free;
    logic                                is_load;
    logic                                load_go;
    logic                                pix_issue;
    logic                                pix_last;
    logic signed [lr_pkg::ERR_W-1:0]     err_sum;
    logic signed [lr_pkg::ERR_W-1:0]     load_err;
    logic [lr_pkg::X_W-1:0]              pix_x;
    logic [lr_pkg::Y_W-1:0]              pix_y;
    logic [lr_pkg::POS_W-1:0]            pix_ysel;

    assign out_free  = !r_out_valid || m_axis_tready;
    assign is_load   = i_cmd.kind == lr_pkg::KIND_LOAD;
    assign load_go   = i_q_valid && is_load;
    assign pix_issue = i_q_valid && !is_load && r_drawing && out_free;
    assign o_q_pop   = i_q_valid && (is_load || !r_drawing || out_free);

    always_comb begin
        err_sum  = r_err + $signed({2'b00, r_minor_delta});
        load_err = lr_pkg::ERR_W'(0)
                   - $signed({3'b000, i_cmd.major_delta[lr_pkg::POS_W-1:1]});
        pix_x    = r_steep ? r_minor_pos : r_major_pos;
        pix_ysel = r_steep ? r_major_pos : r_minor_pos;
        pix_y    = pix_ysel[lr_pkg::Y_W-1:0];

        n_major_pos = r_major_pos + 1'b1;
        n_minor_pos = r_minor_pos;
        n_err       = err_sum;
        if (err_sum > $signed(lr_pkg::ERR_W'(0))) begin
            n_minor_pos = r_minor_down ? r_minor_pos - 1'b1 : r_minor_pos + 1'b1;
            n_err       = err_sum - $signed({2'b00, r_major_delta});
        end
        pix_last  = n_major_pos == r_major_stop;

        n_drawing = r_drawing;
        if (load_go) begin
            n_drawing = i_cmd.major_delta != '0;
        end else if (pix_issue && pix_last) begin
            n_drawing = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_drawing <= n_drawing;
            if (pix_issue) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_go) begin
            r_steep       <= i_cmd.steep;
            r_major_pos   <= i_cmd.major_pos;
            r_minor_pos   <= i_cmd.minor_pos;
            r_major_stop  <= i_cmd.major_stop;
            r_major_delta <= i_cmd.major_delta;
            r_minor_delta <= i_cmd.minor_delta;
            r_minor_down  <= i_cmd.minor_down;
            r_err         <= load_err;
            r_colour      <= i_cmd.colour;
        end else if (pix_issue) begin
            r_major_pos <= n_major_pos;
            r_minor_pos <= n_minor_pos;
            r_err       <= n_err;
        end
        if (pix_issue) begin
            r_out_x      <= pix_x;
            r_out_y      <= pix_y;
            r_out_colour <= r_colour;
            r_out_addr   <= lr_pkg::pixel_addr(i_frame_base, pix_x, pix_y);
            r_out_last   <= pix_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign o_tdata       = {7'b0000000, r_out_addr, r_out_colour, r_out_y, r_out_x};

    assign o_status.drawing   = r_drawing;
    assign o_status.pix_issue = pix_issue;
    assign o_status.pix_last  = pix_last;

endmodule

FILE: tb/line_rasterizer_top_tb.sv
// Self-checking testbench for the line rasterizer: directed lines, then random lines.
`timescale 1ns / 100ps

module line_rasterizer_top_tb;

    localparam int LIMIT_CYCLES  = 200_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 100;
    localparam int IDLE_PCT      = 33;

    typedef struct {
        logic [lr_pkg::X_W-1:0]      x;
        logic [lr_pkg::Y_W-1:0]      y;
        logic [lr_pkg::COLOUR_W-1:0] colour;
        logic [lr_pkg::ADDR_W-1:0]   addr;
        logic                        last;
    } t_pixel;

    typedef struct {
        lr_pkg::t_kind             kind;
        int                        sx;
        int                        sy;
        int                        ex;
        int                        ey;
        int                        colour;
        bit                        typed;
        int                        wx;
        int                        wy;
        int                        wcolour;
        logic [lr_pkg::ADDR_W-1:0] waddr;
        bit                        wlast;
    } t_plan_row;

    logic                         i_clk;
    logic                         i_rst_n       = 1'b0;
    logic                         i_cfg_valid   = 1'b0;
    logic                         o_cfg_ready;
    logic [lr_pkg::ADDR_W-1:0]    i_cfg_data    = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [lr_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                         s_axis_tuser  = lr_pkg::KIND_LOAD;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [lr_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                         m_axis_tlast;

    line_rasterizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Line state mirrored from the block.
    logic [lr_pkg::ADDR_W-1:0]   frame_base;
    logic [lr_pkg::POS_W-1:0]    maj_pos;
    logic [lr_pkg::POS_W-1:0]    min_pos;
    logic [lr_pkg::POS_W-1:0]    maj_stop;
    logic [lr_pkg::POS_W-1:0]    maj_delta;
    logic [lr_pkg::POS_W-1:0]    min_delta;
    int                          err_acc;
    bit                          min_down;
    bit                          steep;
    logic [lr_pkg::COLOUR_W-1:0] colour_held;
    bit                          line_active;

    t_pixel pending_pixels[$];
    bit     calm = 1'b0;
    int     cycle_count = 0;
    int     errors = 0;
    int     requests_sent = 0;
    int     lines_loaded = 0;
    int     pixels_checked = 0;

    t_plan_row plan [0:24] = '{
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_LOAD, 0, 0, 3, 0, 'hFFFF, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 1, 0, 0, 'hFFFF, 0, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 1, 1, 0, 'hFFFF, 2, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 1, 2, 0, 'hFFFF, 4, 1},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_LOAD, 5, 5, 5, 5, 'h1234, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_LOAD, 319, 239, 317, 239, 0, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 1, 317, 239, 0, 245370, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 1, 318, 239, 0, 245372, 1},
        '{lr_pkg::KIND_LOAD, 10, 20, 12, 14, 'hA5A5, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_LOAD, 0, 0, 2, 2, 'h5A5A, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_LOAD, 256, 128, 0, 0, 'h8001, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_LOAD, 7, 3, 7, 9, 'h00FF, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{lr_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic int abs_gap(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [lr_pkg::S_TDATA_W-1:0] pack_line(input int sx, input int sy,
                                                                input int ex, input int ey,
                                                                input int colour);
        return {6'b0, colour[15:0], ey[7:0], ex[8:0], sy[7:0], sx[8:0]};
    endfunction

    // Advances the mirrored line state by one request; made is set when a pixel comes out.
    function automatic void rasterize(input lr_pkg::t_kind kind,
                                      input logic [lr_pkg::S_TDATA_W-1:0] d,
                                      output bit made, output t_pixel px);
        int ax;
        int ay;
        int bx;
        int by;
        int p0;
        int q0;
        int p1;
        int q1;
        int t;
        made = 1'b0;
        px = '{default: '0};
        if (kind == lr_pkg::KIND_LOAD) begin
            ax = int'(d[8:0]);
            ay = int'(d[16:9]);
            bx = int'(d[25:17]);
            by = int'(d[33:26]);
            steep = abs_gap(ay, by) > abs_gap(ax, bx);
            if (steep) begin
                p0 = ay; q0 = ax; p1 = by; q1 = bx;
            end else begin
                p0 = ax; q0 = ay; p1 = bx; q1 = by;
            end
            if (p0 > p1) begin
                t = p0; p0 = p1; p1 = t;
                t = q0; q0 = q1; q1 = t;
            end
            maj_pos = lr_pkg::POS_W'(p0);
            maj_stop = lr_pkg::POS_W'(p1);
            maj_delta = lr_pkg::POS_W'(p1 - p0);
            min_pos = lr_pkg::POS_W'(q0);
            min_delta = lr_pkg::POS_W'(abs_gap(q0, q1));
            min_down = q0 > q1;
            err_acc = -(int'(maj_delta) / 2);
            colour_held = d[49:34];
            line_active = maj_delta != 0;
        end else if (line_active) begin
            made = 1'b1;
            if (steep) begin
                px.x = min_pos;
                px.y = maj_pos[lr_pkg::Y_W-1:0];
            end else begin
                px.x = maj_pos;
                px.y = min_pos[lr_pkg::Y_W-1:0];
            end
            px.colour = colour_held;
            px.addr = frame_base + (lr_pkg::ADDR_W'(px.y) << lr_pkg::ROW_SHIFT)
                      + (lr_pkg::ADDR_W'(px.x) << 1);
            err_acc = err_acc + int'(min_delta);
            if (err_acc > 0) begin
                min_pos = min_down ? min_pos - 1'b1 : min_pos + 1'b1;
                err_acc = err_acc - int'(maj_delta);
            end
            maj_pos = maj_pos + 1'b1;
            px.last = maj_pos == maj_stop;
            if (px.last)
                line_active = 1'b0;
        end
    endfunction

    task automatic send_request(input lr_pkg::t_kind kind,
                                input logic [lr_pkg::S_TDATA_W-1:0] d);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
        if (kind == lr_pkg::KIND_LOAD)
            lines_loaded++;
    endtask

    // Sends one request and queues the pixel it should produce; returns 1 unless ignored.
    task automatic issue(input lr_pkg::t_kind kind, input logic [lr_pkg::S_TDATA_W-1:0] d,
                         output bit counted);
        bit     made;
        t_pixel px;
        counted = (kind == lr_pkg::KIND_LOAD) || line_active;
        send_request(kind, d);
        rasterize(kind, d, made, px);
        if (made)
            pending_pixels.push_back(px);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_base(input logic [lr_pkg::ADDR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        frame_base = value;
    endtask

    task automatic random_line(output logic [lr_pkg::S_TDATA_W-1:0] d);
        int span;
        int sx;
        int sy;
        int ex;
        int ey;
        int r;
        r = $urandom_range(0, 99);
        span = (r < 70) ? 12 : (r < 95) ? 60 : 320;
        sx = $urandom_range(0, 319);
        sy = $urandom_range(0, 239);
        ex = sx + $urandom_range(0, 2 * span) - span;
        ey = sy + $urandom_range(0, 2 * span) - span;
        ex = (ex < 0) ? 0 : (ex > 319) ? 319 : ex;
        ey = (ey < 0) ? 0 : (ey > 239) ? 239 : ey;
        d = pack_line(sx, sy, ex, ey, $urandom_range(0, 65535));
    endtask

    function automatic logic [lr_pkg::S_TDATA_W-1:0] random_data();
        return pack_line($urandom_range(0, 319), $urandom_range(0, 239),
                         $urandom_range(0, 319), $urandom_range(0, 239),
                         $urandom_range(0, 65535));
    endfunction

    task automatic check_field(input string name, input logic [lr_pkg::ADDR_W-1:0] want,
                               input logic [lr_pkg::ADDR_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: pixel x=%0d y=%0d arrived with no request pending", $time,
                         m_axis_tdata[8:0], m_axis_tdata[16:9]);
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                check_field("pixel_x", lr_pkg::ADDR_W'(want.x),
                            lr_pkg::ADDR_W'(m_axis_tdata[8:0]));
                check_field("pixel_y", lr_pkg::ADDR_W'(want.y),
                            lr_pkg::ADDR_W'(m_axis_tdata[16:9]));
                check_field("pixel_colour", lr_pkg::ADDR_W'(want.colour),
                            lr_pkg::ADDR_W'(m_axis_tdata[32:17]));
                check_field("pixel_address", want.addr, m_axis_tdata[64:33]);
                check_field("last_pixel", lr_pkg::ADDR_W'(want.last),
                            lr_pkg::ADDR_W'(m_axis_tlast));
                check_field("tdata pad", '0,
                            lr_pkg::ADDR_W'(m_axis_tdata[lr_pkg::M_TDATA_W-1:65]));
            end
        end
    end

    initial begin
        logic [lr_pkg::ADDR_W-1:0]    bases [0:4];
        logic [lr_pkg::S_TDATA_W-1:0] d;
        t_pixel                       px;
        bit                           made;
        bit                           counted;
        int                           phase_count;
        int                           steps;
        int                           len;

        frame_base = '0;
        maj_pos = '0;
        min_pos = '0;
        maj_stop = '0;
        maj_delta = '0;
        min_delta = '0;
        err_acc = 0;
        min_down = 1'b0;
        steep = 1'b0;
        colour_held = '0;
        line_active = 1'b0;
        bases[0] = 32'hFFFF_FFFF;
        bases[1] = 32'h8000_0000;
        bases[2] = $urandom;
        bases[3] = 32'hFFFF_FC00;
        bases[4] = 32'h0000_0000;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            d = pack_line(plan[i].sx, plan[i].sy, plan[i].ex, plan[i].ey, plan[i].colour);
            if (plan[i].typed) begin
                send_request(plan[i].kind, d);
                rasterize(plan[i].kind, d, made, px);
                pending_pixels.push_back('{lr_pkg::X_W'(plan[i].wx),
                                           lr_pkg::Y_W'(plan[i].wy),
                                           lr_pkg::COLOUR_W'(plan[i].wcolour),
                                           plan[i].waddr, plan[i].wlast});
            end else begin
                issue(plan[i].kind, d, counted);
            end
        end

        for (int phase = 0; phase < 5; phase++) begin
            settle();
            write_frame_base(bases[phase]);
            calm = (phase == 1);
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85) begin
                    random_line(d);
                    issue(lr_pkg::KIND_LOAD, d, counted);
                    phase_count++;
                    len = int'(maj_delta);
                    steps = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len)
                                                        : len + $urandom_range(0, 2);
                    repeat (steps) begin
                        issue(lr_pkg::KIND_STEP, random_data(), counted);
                        phase_count += int'(counted);
                    end
                end else begin
                    issue($urandom_range(0, 1) ? lr_pkg::KIND_STEP : lr_pkg::KIND_LOAD,
                          random_data(), counted);
                    phase_count += int'(counted);
                end
            end
        end
        calm = 1'b0;
        settle();

        $display("Sent %0d requests across %0d lines at five frame bases; %0d pixels checked.",
                 requests_sent, lines_loaded, pixels_checked);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches found.", errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: line_rasterizer_top.f
hw/rtl/lr_pkg.sv
hw/rtl/lr_front.sv
hw/rtl/lr_queue.sv
hw/rtl/lr_back.sv
hw/rtl/line_rasterizer_top.sv
tb/line_rasterizer_top_tb.sv
